/* hdl/dhpc_pkg.sv */
package dhpc_pkg;

   localparam logic [6:0] MOD_STEPS   = 7'd100;
   localparam logic [6:0] DUTY_MAX    = 7'd100;
   localparam logic [9:0] ERR_LIMIT   = 10'd10;
   localparam logic [3:0] SAMPLE_LAST = 4'd8;

   localparam logic [6:0]  POWER_BASE_RESET   = 7'd0;
   localparam logic [15:0] TICKS_PER_SEC_RESET = 16'd1000;
   localparam logic [7:0]  DOOR_BLOCK_RESET   = 8'd120;
   localparam logic [7:0]  DOOR_REARM_RESET   = 8'd240;

   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      REG_POWER_BASE    = 2'd0,
      REG_TICKS_PER_SEC = 2'd1,
      REG_DOOR_BLOCK    = 2'd2,
      REG_DOOR_REARM    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       start_top;
      logic       start_bot;
      logic       service_mode;
      logic       door_top_open;
      logic       door_bot_open;
      logic [9:0] top_temp;
      logic [9:0] top_error;
      logic [9:0] top_setpoint;
      logic [9:0] bot_temp;
      logic [9:0] bot_error;
      logic [9:0] bot_setpoint;
   } req_item_type;

   typedef struct packed {
      logic       top_heater_on;
      logic       bot_heater_on;
      logic [6:0] top_duty;
      logic [6:0] bot_duty;
      logic       top_door_block;
      logic       bot_door_block;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0] power_base;
      logic [7:0] door_block_seconds;
      logic [7:0] door_rearm_seconds;
   } zone_cfg_type;

   typedef struct packed {
      logic step;
      logic second;
      logic sample;
   } zone_ctrl_type;

   typedef struct packed {
      logic       start;
      logic       service;
      logic       door_open;
      logic [9:0] temp;
      logic [9:0] error;
      logic [9:0] setpoint;
   } zone_in_type;

   typedef struct packed {
      logic       heater_on;
      logic [6:0] duty;
      logic       door_block;
   } zone_out_type;

endpackage

/* hdl/dhpc_if.sv */
interface dhpc_req_if;
   logic                  valid;
   logic                  ready;
   dhpc_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dhpc_rsp_if;
   logic                  valid;
   logic                  ready;
   dhpc_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hdl/dhpc_timebase.sv */
module dhpc_timebase (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [15:0]             ticks_per_second,
   output dhpc_pkg::zone_ctrl_type ctrl
);
   import dhpc_pkg::*;

   logic [15:0] tick_ff, tick_in;
   logic [3:0]  sample_ff, sample_in;
   logic        second;
   logic        sample;

   always_comb begin
      second    = (tick_ff >= ticks_per_second);
      sample    = second && (sample_ff >= SAMPLE_LAST);
      tick_in   = second ? 16'd0 : tick_ff + 16'd1;
      sample_in = sample_ff;
      if (sample) begin
         sample_in = 4'd0;
      end else if (second) begin
         sample_in = sample_ff + 4'd1;
      end
      ctrl.step   = step;
      ctrl.second = step && second;
      ctrl.sample = step && sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= 16'd0;
         sample_ff <= 4'd0;
      end else if (step) begin
         tick_ff   <= tick_in;
         sample_ff <= sample_in;
      end
   end

endmodule

/* hdl/dhpc_zone.sv */
module dhpc_zone (
   input  logic                    clock,
   input  logic                    reset,
   input  dhpc_pkg::zone_ctrl_type ctrl,
   input  dhpc_pkg::zone_cfg_type  cfg,
   input  dhpc_pkg::zone_in_type   zin,
   output dhpc_pkg::zone_out_type  zout
);
   import dhpc_pkg::*;

   logic [6:0] mod_count_ff, mod_count_in;
   logic       pin_ff, pin_in;
   logic [8:0] door_secs_ff, door_secs_in;
   logic       block_ff, block_in;
   logic [9:0] prev_temp_ff, prev_temp_in;
   logic [6:0] duty_ff, duty_in;
   logic [6:0] accrual_ff, accrual_in;

   logic [6:0] mod_step;
   logic [6:0] accrual_mid;
   logic [8:0] door_inc;
   logic [7:0] acc_sum;
   logic [7:0] err_sq;
   logic [7:0] duty_sum;

   always_comb begin
      // The counter runs 100 down to 1; zero or one reloads the top value.
      mod_step = (mod_count_ff <= 7'd1) ? MOD_STEPS : mod_count_ff - 7'd1;
      if (zin.start && !block_ff) begin
         mod_count_in = mod_step;
         // count < duty - base, written without a signed difference.
         pin_in       = ({1'b0, mod_step} + {1'b0, cfg.power_base}) < {1'b0, duty_ff};
         accrual_mid  = accrual_ff;
      end else begin
         mod_count_in = 7'd0;
         pin_in       = zin.service ? pin_ff : 1'b0;
         accrual_mid  = 7'd0;
      end

      door_inc     = door_secs_ff + 9'd1;
      door_secs_in = door_secs_ff;
      block_in     = block_ff;
      if (ctrl.second) begin
         if (zin.door_open) begin
            block_in     = door_inc > {1'b0, cfg.door_block_seconds};
            door_secs_in = (door_inc > {1'b0, cfg.door_rearm_seconds}) ? 9'd0 : door_inc;
         end else begin
            block_in     = 1'b0;
            door_secs_in = 9'd0;
         end
      end

      // The error is at most ten on the accrual path, so four bits carry it.
      acc_sum      = {1'b0, accrual_mid} + {4'd0, zin.error[3:0]};
      err_sq       = {4'd0, zin.error[3:0]} * {4'd0, zin.error[3:0]};
      accrual_in   = accrual_mid;
      duty_in      = duty_ff;
      prev_temp_in = prev_temp_ff;
      if (ctrl.sample) begin
         prev_temp_in = zin.temp;
         if ((zin.temp < prev_temp_ff) || (zin.error > ERR_LIMIT)) begin
            if (zin.temp <= zin.setpoint) begin
               duty_in = DUTY_MAX;
            end
         end else begin
            if (zin.temp > prev_temp_ff) begin
               accrual_in = 7'd0;
            end else begin
               accrual_in = (acc_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : acc_sum[6:0];
            end
         end
      end
      duty_sum = err_sq + {1'b0, accrual_in};
      if (ctrl.sample && !((zin.temp < prev_temp_ff) || (zin.error > ERR_LIMIT))) begin
         duty_in = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[6:0];
      end

      zout.heater_on  = pin_in;
      zout.duty       = duty_in;
      zout.door_block = block_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_count_ff <= 7'd0;
         pin_ff       <= 1'b0;
         door_secs_ff <= 9'd0;
         block_ff     <= 1'b0;
         prev_temp_ff <= 10'd0;
         duty_ff      <= 7'd0;
         accrual_ff   <= 7'd0;
      end else if (ctrl.step) begin
         mod_count_ff <= mod_count_in;
         pin_ff       <= pin_in;
         door_secs_ff <= door_secs_in;
         block_ff     <= block_in;
         prev_temp_ff <= prev_temp_in;
         duty_ff      <= duty_in;
         accrual_ff   <= accrual_in;
      end
   end

endmodule

/* hdl/dual_heater_pwm_controller.sv */
// Each item is held in the input register, its result in the result register.
// Throughput: one item per cycle while results are taken; each register holds one
// item, so while a result waits one more item can still enter.
// Reset (synchronous, active high) clears all zone state, the tick and sample
// counters, and loads the register defaults; no clearing pass is needed.
module dual_heater_pwm_controller (
   input  logic                             clock,
   input  logic                             reset,
   dhpc_req_if.sink                         req_chan,
   dhpc_rsp_if.source                       rsp_chan,
   input  logic                             csr_write,
   input  dhpc_pkg::csr_index_type          csr_index,
   input  logic [dhpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dhpc_pkg::*;

   logic [6:0]  power_base_ff;
   logic [15:0] ticks_per_sec_ff;
   logic [7:0]  door_block_ff;
   logic [7:0]  door_rearm_ff;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;

   logic          advance;
   zone_ctrl_type ctrl;
   zone_cfg_type  cfg;
   zone_in_type   top_in, bot_in;
   zone_out_type  top_out, bot_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_base_ff    <= POWER_BASE_RESET;
         ticks_per_sec_ff <= TICKS_PER_SEC_RESET;
         door_block_ff    <= DOOR_BLOCK_RESET;
         door_rearm_ff    <= DOOR_REARM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_POWER_BASE:    power_base_ff    <= csr_wdata[6:0];
            REG_TICKS_PER_SEC: ticks_per_sec_ff <= csr_wdata[15:0];
            REG_DOOR_BLOCK:    door_block_ff    <= csr_wdata[7:0];
            REG_DOOR_REARM:    door_rearm_ff    <= csr_wdata[7:0];
         endcase
      end
   end

   // The held item is processed whenever the result register is free or drains.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff <= req_chan.data;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   always_comb begin
      cfg.power_base         = power_base_ff;
      cfg.door_block_seconds = door_block_ff;
      cfg.door_rearm_seconds = door_rearm_ff;

      top_in.start     = in_item_ff.start_top;
      top_in.service   = in_item_ff.service_mode;
      top_in.door_open = in_item_ff.door_top_open;
      top_in.temp      = in_item_ff.top_temp;
      top_in.error     = in_item_ff.top_error;
      top_in.setpoint  = in_item_ff.top_setpoint;

      bot_in.start     = in_item_ff.start_bot;
      bot_in.service   = in_item_ff.service_mode;
      bot_in.door_open = in_item_ff.door_bot_open;
      bot_in.temp      = in_item_ff.bot_temp;
      bot_in.error     = in_item_ff.bot_error;
      bot_in.setpoint  = in_item_ff.bot_setpoint;

      out_item_in.top_heater_on  = top_out.heater_on;
      out_item_in.bot_heater_on  = bot_out.heater_on;
      out_item_in.top_duty       = top_out.duty;
      out_item_in.bot_duty       = bot_out.duty;
      out_item_in.top_door_block = top_out.door_block;
      out_item_in.bot_door_block = bot_out.door_block;
   end

   dhpc_timebase u_timebase (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .ticks_per_second (ticks_per_sec_ff),
      .ctrl             (ctrl)
   );

   dhpc_zone u_top_zone (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .cfg   (cfg),
      .zin   (top_in),
      .zout  (top_out)
   );

   dhpc_zone u_bot_zone (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .cfg   (cfg),
      .zin   (bot_in),
      .zout  (bot_out)
   );

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_item_ff;

endmodule
